// ----- hdl/lu_pkg.sv -----
// Package: constants and state encoding for the no-pivot LU decomposition block.
`timescale 1ns / 1ps
package lu_pkg;

   localparam int MAX_DIM = 8;
   localparam int IDX_W   = 3;                 // bits of a row or column index
   localparam int ADDR_W  = 2 * IDX_W;         // bits of a matrix cell address
   localparam int CELLS   = MAX_DIM * MAX_DIM;
   localparam int DIV_W   = 48;                // dividend width: a 32-bit value times 2^16
   localparam int DCNT_W  = 6;

   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [3:0]  SIZE_RESET = 4'd8;

   // register index of matrix_size
   localparam logic REG_MATRIX_SIZE = 1'b0;

   typedef enum logic [10:0] {
      ST_LOAD  = 11'b000_0000_0001,
      ST_PRD   = 11'b000_0000_0010,
      ST_PWAIT = 11'b000_0000_0100,
      ST_DIV   = 11'b000_0000_1000,
      ST_DFIN  = 11'b000_0001_0000,
      ST_KRD   = 11'b000_0010_0000,
      ST_KMUL  = 11'b000_0100_0000,
      ST_KADJ  = 11'b000_1000_0000,
      ST_KWR   = 11'b001_0000_0000,
      ST_ORD   = 11'b010_0000_0000,
      ST_OEM   = 11'b100_0000_0000
   } state_type;

endpackage

// ----- hdl/lu_decomposition_no_pivot.sv -----
// Top level: loads a Q16.16 matrix, runs Doolittle elimination without pivoting, streams L and U.
`timescale 1ns / 1ps
//
//  channel   ports                        handshake
//  -------   --------------------------   -------------------------------------
//  input     req_element                  beat taken when start high, busy low, no size write
//  result    rsp_*                        rsp_valid high one cycle, always taken
//  config    psel/penable/pwrite/paddr    APB write in access phase, pready tied high
//
//  Loading accepts one element per cycle while start is high and no size write is made.
//  After the last element, each row pair (i, j) goes through pivot read, the bit-serial
//  divider, storing the multiplier and, per column, read, multiply, scale and write back,
//  on a two-read-port working memory; the multipliers go to a separate memory. A zero
//  pivot skips the divider and column loop. Each result is a memory read, then present.
//  Synchronous active-high reset returns to loading with matrix_size 8; the matrix
//  memories are not cleared. The receiver cannot stall, so nothing waits on the output.
module lu_decomposition_no_pivot
   import lu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_element,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_lower_value,
   output logic signed [31:0]  rsp_upper_value,
   output logic [2:0]          rsp_row_index,
   output logic [2:0]          rsp_col_index,
   output logic                rsp_zero_pivot,
   output logic                rsp_last_result,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   state_type state_ff, state_in;

   logic [3:0]         size_ff, size_in;
   logic [IDX_W-1:0]   lrow_ff, lrow_in, lcol_ff, lcol_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0]   orow_ff, orow_in, ocol_ff, ocol_in;
   logic               zp_ff, zp_in;
   logic signed [31:0] m_ff, m_in;
   logic [31:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]   num_ff, num_in, quo_ff, quo_in;
   logic [31:0]        den_ff, den_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic               qneg_ff, qneg_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] p_ff, p_in;

   // matrix memories
   logic [31:0] work_mem  [CELLS];
   logic [31:0] lower_mem [CELLS];
   logic [31:0] rd_a_q, rd_b_q, lo_q;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr, lo_wr_addr;
   logic [31:0] wr_data, lo_wr_data;
   logic        wr_en, lo_wr_en;

   logic [3:0]  dim;
   logic        cfg_wr;
   logic        accept;

   // effective size: 0 acts as 1, above MAX_DIM acts as MAX_DIM
   always_comb begin
      if (size_ff == 4'd0) begin
         dim = 4'd1;
      end else if (size_ff > 4'(MAX_DIM)) begin
         dim = 4'(MAX_DIM);
      end else begin
         dim = size_ff;
      end
   end

   function automatic logic is_last(input logic [IDX_W-1:0] x, input logic [3:0] d);
      return ({1'b0, x} + 4'd1) == d;
   endfunction

   assign cfg_wr = psel & penable & pwrite & pready;
   assign accept = start & ~busy;
   assign busy   = (state_ff != ST_LOAD);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {28'd0, size_ff} : 32'd0;

   // divider step
   logic [32:0] rem_sh;
   logic        rem_ge;
   assign rem_sh = {rem_ff, num_ff[DIV_W-1]};
   assign rem_ge = rem_sh >= {1'b0, den_ff};

   // quotient saturation
   logic signed [31:0] m_sat;
   always_comb begin
      if (qneg_ff) begin
         if (quo_ff > DIV_W'(64'h8000_0000)) begin
            m_sat = 32'sh8000_0000;
         end else begin
            m_sat = -$signed(quo_ff[31:0]);
         end
      end else begin
         if (quo_ff >= DIV_W'(64'h8000_0000)) begin
            m_sat = 32'sh7FFF_FFFF;
         end else begin
            m_sat = $signed(quo_ff[31:0]);
         end
      end
   end

   // scale product by 2^-16 toward zero and saturate
   logic signed [63:0] prod_adj;
   logic signed [47:0] prod_q;
   logic signed [31:0] p_sat;
   assign prod_adj = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
   assign prod_q   = prod_adj[63:16];
   always_comb begin
      if (prod_q > 48'sh0000_7FFF_FFFF) begin
         p_sat = 32'sh7FFF_FFFF;
      end else if (prod_q < -48'sh0000_8000_0000) begin
         p_sat = 32'sh8000_0000;
      end else begin
         p_sat = prod_q[31:0];
      end
   end

   // subtract and saturate
   logic signed [32:0] diff;
   logic signed [31:0] diff_sat;
   assign diff = {rd_b_q[31], rd_b_q} - {p_ff[31], p_ff};
   always_comb begin
      if (diff[32] != diff[31]) begin
         diff_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         diff_sat = diff[31:0];
      end
   end

   // read addresses by state
   always_comb begin
      rd_a_addr = {orow_ff, ocol_ff};
      rd_b_addr = {j_ff, k_ff};
      case (state_ff)
         ST_PRD, ST_PWAIT: begin
            rd_a_addr = {i_ff, i_ff};
            rd_b_addr = {j_ff, i_ff};
         end
         ST_KRD, ST_KMUL, ST_KADJ, ST_KWR: begin
            rd_a_addr = {i_ff, k_ff};
            rd_b_addr = {j_ff, k_ff};
         end
         default: begin
            rd_a_addr = {orow_ff, ocol_ff};
            rd_b_addr = {j_ff, k_ff};
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      lrow_in  = lrow_ff;
      lcol_in  = lcol_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      zp_in    = zp_ff;
      m_in     = m_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      dcnt_in  = dcnt_ff;
      qneg_in  = qneg_ff;
      prod_in  = prod_ff;
      p_in     = p_ff;
      wr_en      = 1'b0;
      wr_addr    = {lrow_ff, lcol_ff};
      wr_data    = req_element;
      lo_wr_en   = 1'b0;
      lo_wr_addr = {j_ff, i_ff};
      lo_wr_data = m_sat;

      case (state_ff)
         ST_LOAD: begin
            if (cfg_wr && paddr[2] == REG_MATRIX_SIZE) begin
               size_in = pwdata[3:0];
               lrow_in = '0;
               lcol_in = '0;
            end else if (accept) begin
               wr_en = 1'b1;
               if (is_last(lcol_ff, dim)) begin
                  lcol_in = '0;
                  if (is_last(lrow_ff, dim)) begin
                     lrow_in = '0;
                     zp_in   = 1'b0;
                     orow_in = '0;
                     ocol_in = '0;
                     i_in    = '0;
                     j_in    = IDX_W'(1);
                     state_in = (dim > 4'd1) ? ST_PRD : ST_ORD;
                  end else begin
                     lrow_in = lrow_ff + IDX_W'(1);
                  end
               end else begin
                  lcol_in = lcol_ff + IDX_W'(1);
               end
            end
         end
         ST_PRD: begin
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (rd_a_q == 32'd0) begin
               // zero pivot: multiplier zero, row unchanged
               zp_in      = 1'b1;
               lo_wr_en   = 1'b1;
               lo_wr_data = 32'd0;
               state_in   = ST_ORD;
               if (!is_last(j_ff, dim)) begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_PRD;
               end else if (({1'b0, i_ff} + 4'd2) < dim) begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = i_ff + IDX_W'(2);
                  state_in = ST_PRD;
               end
            end else begin
               num_in  = {(rd_b_q[31] ? -rd_b_q : rd_b_q), 16'd0};
               den_in  = rd_a_q[31] ? -rd_a_q : rd_a_q;
               qneg_in = rd_a_q[31] ^ rd_b_q[31];
               rem_in  = '0;
               quo_in  = '0;
               dcnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
            quo_in  = {quo_ff[DIV_W-2:0], rem_ge};
            num_in  = {num_ff[DIV_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            m_in     = m_sat;
            lo_wr_en = 1'b1;
            k_in     = '0;
            state_in = ST_KRD;
         end
         ST_KRD: begin
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            prod_in  = $signed(rd_a_q) * m_ff;
            state_in = ST_KADJ;
         end
         ST_KADJ: begin
            p_in     = p_sat;
            state_in = ST_KWR;
         end
         ST_KWR: begin
            // write back; the eliminated entry becomes exactly zero
            wr_en   = 1'b1;
            wr_addr = {j_ff, k_ff};
            wr_data = (k_ff == i_ff) ? 32'd0 : diff_sat;
            if (is_last(k_ff, dim)) begin
               state_in = ST_ORD;
               if (!is_last(j_ff, dim)) begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_PRD;
               end else if (({1'b0, i_ff} + 4'd2) < dim) begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = i_ff + IDX_W'(2);
                  state_in = ST_PRD;
               end
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_KRD;
            end
         end
         ST_ORD: begin
            state_in = ST_OEM;
         end
         ST_OEM: begin
            state_in = ST_ORD;
            if (is_last(ocol_ff, dim)) begin
               ocol_in = '0;
               if (is_last(orow_ff, dim)) begin
                  orow_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  orow_in = orow_ff + IDX_W'(1);
               end
            end else begin
               ocol_in = ocol_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         size_ff  <= SIZE_RESET;
         lrow_ff  <= '0;
         lcol_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         orow_ff  <= '0;
         ocol_ff  <= '0;
         zp_ff    <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         lrow_ff  <= lrow_in;
         lcol_ff  <= lcol_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         orow_ff  <= orow_in;
         ocol_ff  <= ocol_in;
         zp_ff    <= zp_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      qneg_ff <= qneg_in;
      prod_ff <= prod_in;
      p_ff    <= p_in;
   end

   // working matrix: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         work_mem[wr_addr] <= wr_data;
      end
      rd_a_q <= work_mem[rd_a_addr];
      rd_b_q <= work_mem[rd_b_addr];
   end

   // multipliers below the diagonal
   always_ff @(posedge clock) begin
      if (lo_wr_en) begin
         lower_mem[lo_wr_addr] <= lo_wr_data;
      end
      lo_q <= lower_mem[rd_a_addr];
   end

   // result beat
   assign rsp_valid       = (state_ff == ST_OEM);
   assign rsp_row_index   = orow_ff;
   assign rsp_col_index   = ocol_ff;
   assign rsp_upper_value = rd_a_q;
   assign rsp_zero_pivot  = zp_ff;
   assign rsp_last_result = is_last(orow_ff, dim) & is_last(ocol_ff, dim);
   always_comb begin
      if (orow_ff == ocol_ff) begin
         rsp_lower_value = Q_ONE;
      end else if (orow_ff < ocol_ff) begin
         rsp_lower_value = 32'sd0;
      end else begin
         rsp_lower_value = lo_q;
      end
   end

   // a result beat only while busy
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");

   // the last beat returns the block to loading
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !busy) else $error("busy after last beat");

   // result positions stay inside the matrix
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_row_index} < dim) && ({1'b0, rsp_col_index} < dim))
      else $error("result position out of range");

endmodule
